// ===== rtl/murmur3_32_hash_unit_assert.svh =====
// Assertion macros for the murmur3 hash unit checker.
`ifndef MURMUR3_32_HASH_UNIT_ASSERT_SVH
`define MURMUR3_32_HASH_UNIT_ASSERT_SVH

// same-cycle implication, held off during reset
`define MM3_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define MM3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers reset itself
`define MM3_ASSERT_RST(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mm3_pkg.sv =====
// Shared types and constants of the murmur3 hash unit.
`timescale 1ns / 1ps

package mm3_pkg;

  localparam logic [31:0] C1        = 32'hcc9e2d51;
  localparam logic [31:0] C2        = 32'h1b873593;
  localparam logic [31:0] MixAdd    = 32'he6546b64;
  localparam logic [31:0] FinMulA   = 32'h85ebca6b;
  localparam logic [31:0] FinMulB   = 32'hc2b2ae35;
  localparam logic [31:0] SeedReset = 32'd13;
  localparam int          QueueDepth = 4;

  localparam logic [2:0]  CountFull = 3'd4;

  // one scrambled key word on its way to the mixer
  typedef struct packed {
    logic [31:0] k;
    logic [2:0]  count;
    logic        last;
  } mm3_word_t;

  typedef enum logic [1:0] {
    ST_MIX,
    ST_FIN_A,
    ST_FIN_B,
    ST_OUT
  } mm3_state_t;

endpackage

// ===== rtl/mm3_channels.sv =====
// Channel interfaces: key words in, hash words out, seed writes.
`timescale 1ns / 1ps

interface mm3_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        last;
  modport source(output valid, data_word, byte_count, last, input ready);
  modport sink(input valid, data_word, byte_count, last, output ready);
endinterface

interface mm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;
  modport source(output valid, hash_value, input ready);
  modport sink(input valid, hash_value, output ready);
endinterface

interface mm3_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] seed;
  modport source(output valid, seed, input ready);
  modport sink(input valid, seed, output ready);
endinterface

// ===== rtl/mm3_front.sv =====
// Front end: takes key words, trims the tail bytes and scrambles k in two stages.
`timescale 1ns / 1ps

module mm3_front (
  input  logic               clk,
  input  logic               rst_n,
  mm3_in_if.sink             in_ch,
  output logic               push,
  output mm3_pkg::mm3_word_t push_word,
  input  logic               full
);
  import mm3_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  logic [31:0] s1_prod_r;
  logic [2:0]  s1_cnt_r;
  logic        s1_last_r;
  logic        s2_valid_r, s2_valid_nxt;
  mm3_word_t   s2_word_r;

  logic        s2_adv;
  logic        s1_adv;
  logic [2:0]  cnt;
  logic [31:0] mask;
  logic [31:0] rot;

  // counts above four act as a full word
  assign cnt = in_ch.byte_count[2] ? CountFull : in_ch.byte_count;

  always_comb begin
    unique case (cnt)
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      3'd4:    mask = 32'hffff_ffff;
      default: mask = 32'h0000_0000;
    endcase
  end

  assign push      = s2_valid_r;
  assign push_word = s2_word_r;
  assign s2_adv    = !s2_valid_r || !full;
  assign s1_adv    = !s1_valid_r || s2_adv;
  assign in_ch.ready = s1_adv;

  assign rot = {s1_prod_r[16:0], s1_prod_r[31:17]};

  always_comb begin
    s1_valid_nxt = s1_adv ? in_ch.valid : s1_valid_r;
    s2_valid_nxt = s2_adv ? s1_valid_r : s2_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_ch.valid) begin
      s1_prod_r <= (in_ch.data_word & mask) * C1;
      s1_cnt_r  <= cnt;
      s1_last_r <= in_ch.last;
    end
    if (s2_adv && s1_valid_r) begin
      s2_word_r.k     <= rot * C2;
      s2_word_r.count <= s1_cnt_r;
      s2_word_r.last  <= s1_last_r;
    end
  end

endmodule

// ===== rtl/mm3_fifo.sv =====
// Short word queue between the front end and the mixer.
`timescale 1ns / 1ps

module mm3_fifo #(
  parameter int DEPTH = mm3_pkg::QueueDepth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  mm3_pkg::mm3_word_t push_word,
  output logic               full,
  input  logic               pop,
  output mm3_pkg::mm3_word_t pop_word,
  output logic               empty
);
  import mm3_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mm3_word_t       mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            do_push;
  logic            do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_word = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_word;
    end
  end

endmodule

// ===== rtl/mm3_back.sv =====
// Back end: mixes words into the running hash, finalizes, holds the result word.
`timescale 1ns / 1ps

module mm3_back (
  input  logic               clk,
  input  logic               rst_n,
  mm3_cfg_if.sink            cfg_ch,
  input  mm3_pkg::mm3_word_t q_word,
  input  logic               q_empty,
  output logic               q_pop,
  mm3_out_if.source          out_ch
);
  import mm3_pkg::*;

  mm3_state_t  state_r, state_nxt;
  logic [31:0] seed_r;
  logic [31:0] h_r, h_nxt;
  logic [31:0] total_r, total_nxt;
  logic        busy_r, busy_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;

  logic [31:0] h_base;
  logic [31:0] h_x;
  logic [31:0] h_rot;
  logic [31:0] h_mixed;
  logic [31:0] total_add;

  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.hash_value = out_hash_r;

  // a new key starts from the seed
  assign h_base    = busy_r ? h_r : seed_r;
  assign h_x       = h_base ^ q_word.k;
  assign h_rot     = {h_x[18:0], h_x[31:19]};
  assign total_add = total_r + 32'(q_word.count);

  always_comb begin
    if (q_word.count == CountFull) begin
      h_mixed = {h_rot[29:0], 2'b00} + h_rot + MixAdd;
    end else if (q_word.count != 3'd0) begin
      h_mixed = h_x;
    end else begin
      h_mixed = h_base;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    h_nxt         = h_r;
    total_nxt     = total_r;
    busy_nxt      = busy_r;
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    q_pop         = 1'b0;
    unique case (state_r)
      ST_MIX: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_word.last) begin
            h_nxt     = h_mixed ^ total_add;
            total_nxt = '0;
            busy_nxt  = 1'b0;
            state_nxt = ST_FIN_A;
          end else begin
            h_nxt     = h_mixed;
            total_nxt = total_add;
            busy_nxt  = 1'b1;
          end
        end
      end
      ST_FIN_A: begin
        h_nxt     = (h_r ^ {16'd0, h_r[31:16]}) * FinMulA;
        state_nxt = ST_FIN_B;
      end
      ST_FIN_B: begin
        h_nxt     = (h_r ^ {13'd0, h_r[31:13]}) * FinMulB;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_hash_nxt  = h_r ^ {16'd0, h_r[31:16]};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_MIX;
        end
      end
      default: state_nxt = ST_MIX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_MIX;
      seed_r      <= SeedReset;
      h_r         <= SeedReset;
      total_r     <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      h_r         <= h_nxt;
      total_r     <= total_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        seed_r <= cfg_ch.seed;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_hash_r <= out_hash_nxt;
  end

endmodule

// ===== rtl/murmur3_32_hash_unit.sv =====
// Top level of the MurmurHash3 x86_32 hash unit.
//
//   channel  dir  word                              handshake
//   in_ch    in   data_word, byte_count, last       valid / ready
//   out_ch   out  hash_value                        valid / ready
//   cfg_ch   in   seed                              valid / ready (always ready)
//
// Words that do not end a key are taken one per cycle while the queue is not full;
// the mixer retires one word per cycle from the queue while in ST_MIX.
// A last word holds the mixer through mix, two finalizer multiplies and result load.
// A last word passes s1, s2, the queue, the mixer and finalizer to out_ch.valid.
// Reset is synchronous; seed returns to 13.
// A stalled result blocks the mixer only; the queue keeps taking words until full.
`timescale 1ns / 1ps

module murmur3_32_hash_unit #(
  parameter int QUEUE_DEPTH = mm3_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  mm3_in_if.sink     in_ch,
  mm3_out_if.source  out_ch,
  mm3_cfg_if.sink    cfg_ch
);
  import mm3_pkg::*;

  logic      push;
  mm3_word_t push_word;
  logic      full;
  logic      pop;
  mm3_word_t pop_word;
  logic      empty;

  mm3_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .push      (push),
    .push_word (push_word),
    .full      (full)
  );

  mm3_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .full      (full),
    .pop       (pop),
    .pop_word  (pop_word),
    .empty     (empty)
  );

  mm3_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_ch  (cfg_ch),
    .q_word  (pop_word),
    .q_empty (empty),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== rtl/mm3_checker.sv =====
// Port-level checker for the murmur3 hash unit, bound to the top level.
`timescale 1ns / 1ps
`include "murmur3_32_hash_unit_assert.svh"

module mm3_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_hash
);

  logic [7:0] pending_r, pending_nxt;
  logic       key_end;
  logic       out_take;

  assign key_end  = in_valid && in_ready && in_last;
  assign out_take = out_valid && out_ready;

  // keys ended but not yet answered
  always_comb begin
    pending_nxt = pending_r + 8'(key_end) - 8'(out_take);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  `MM3_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `MM3_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_hash), "result changed while stalled")
  `MM3_ASSERT_RST(a_rst_clear, clk, !rst_n, !out_valid, "result valid after reset")
  `MM3_ASSERT_NOW(a_no_spurious, clk, rst_n, out_valid, pending_r != 8'd0, "result without a finished key")

endmodule

bind murmur3_32_hash_unit mm3_checker u_mm3_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_hash  (out_ch.hash_value)
);

// ===== tb/sv/murmur3_32_hash_unit_test.sv =====
// Self-checking testbench for the murmur3 x86_32 hash unit: directed and random keys.
`timescale 1ns / 1ps

module murmur3_32_hash_unit_test;
  import mm3_pkg::*;

  localparam int CycleLimit = 600000;
  localparam int LongHold   = 300;
  localparam int DrainWait  = 12;

  // Tracks the running hash of the key in flight and queues finished hashes.
  class murmur_hash_tracker;
    logic [31:0] seed_reg;
    logic [31:0] hash_acc;
    logic [31:0] len_acc;
    bit          in_key;
    logic [31:0] expected_hashes[$];
    int          errors;

    function new();
      seed_reg = SeedReset;
      hash_acc = SeedReset;
      len_acc  = '0;
      in_key   = 0;
      errors   = 0;
    endfunction

    function logic [31:0] rol(logic [31:0] x, int r);
      return (x << r) | (x >> (32 - r));
    endfunction

    function logic [31:0] scramble_key(logic [31:0] k);
      k = k * C1;
      k = rol(k, 15);
      k = k * C2;
      return k;
    endfunction

    function logic [31:0] avalanche(logic [31:0] h);
      h = h ^ (h >> 16);
      h = h * FinMulA;
      h = h ^ (h >> 13);
      h = h * FinMulB;
      h = h ^ (h >> 16);
      return h;
    endfunction

    function void load_seed(logic [31:0] v);
      seed_reg = v;
      if (!in_key) hash_acc = v;
    endfunction

    function void take_word(logic [31:0] data, logic [2:0] count, logic last);
      logic [31:0] h;
      logic [31:0] mask;
      logic [2:0]  n;
      if (!in_key) hash_acc = seed_reg;
      h = hash_acc;
      n = (count > CountFull) ? CountFull : count;
      if (n == CountFull) begin
        h = h ^ scramble_key(data);
        h = rol(h, 13);
        h = h * 32'd5 + MixAdd;
      end else if (n != 3'd0) begin
        // tail: no rotate/add, bytes above the count dropped
        mask = (32'd1 << (8 * n)) - 32'd1;
        h = h ^ scramble_key(data & mask);
      end
      len_acc = len_acc + {29'd0, n};
      if (!last) begin
        hash_acc = h;
        in_key   = 1;
      end else begin
        expected_hashes.insert(expected_hashes.size(), avalanche(h ^ len_acc));
        hash_acc = seed_reg;
        len_acc  = '0;
        in_key   = 0;
      end
    endfunction

    function void check_hash(logic [31:0] actual);
      logic [31:0] want;
      if (expected_hashes.size() == 0) begin
        $error("hash_value: expected none, got %h", actual);
        errors++;
      end else begin
        want = expected_hashes.pop_front();
        if (actual !== want) begin
          $error("hash_value: expected %h, got %h", want, actual);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_hashes.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   quiet;
  bit   long_hold;
  int   cycle_count;

  murmur_hash_tracker hash_calc = new();

  mm3_in_if  in_ch();
  mm3_out_if out_ch();
  mm3_cfg_if cfg_ch();

  murmur3_32_hash_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("murmur3_32_hash_unit_test: done, errors");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 40);
  endfunction

  task automatic send_word(logic [31:0] data, logic [2:0] count, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.data_word  = data;
    in_ch.byte_count = count;
    in_ch.last       = last;
    do @(posedge clk); while (!in_ch.ready);
    hash_calc.take_word(data, count, last);
    @(negedge clk);
  endtask

  task automatic write_seed(logic [31:0] v);
    cfg_ch.valid = 1'b1;
    cfg_ch.seed  = v;
    do @(posedge clk); while (!cfg_ch.ready);
    hash_calc.load_seed(v);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (hash_calc.pending() != 0) @(negedge clk);
    repeat (DrainWait) @(negedge clk);
  endtask

  // well-formed keys most of the time; the rest has odd counts anywhere
  task automatic send_random_key(output int words);
    int nfull;
    int i;
    if ($urandom_range(0, 9) < 7) begin
      nfull = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 3);
      for (i = 0; i < nfull; i++) send_word($urandom, CountFull, 1'b0);
      send_word($urandom, 3'($urandom_range(0, 4)), 1'b1);
      words = nfull + 1;
    end else begin
      words = $urandom_range(1, 6);
      for (i = 0; i < words; i++)
        send_word($urandom, 3'($urandom_range(0, 7)), i == words - 1);
    end
  endtask

  task automatic run_keys(int budget);
    int sent;
    int n;
    sent = 0;
    while (sent < budget) begin
      send_random_key(n);
      sent += n;
    end
  endtask

  task automatic run_directed();
    send_word(32'h0, 3'd0, 1'b1);                  // empty key
    send_word(32'hffffff61, 3'd1, 1'b1);           // garbage above the valid bytes
    send_word(32'h5a5a6261, 3'd2, 1'b1);
    send_word(32'hff636261, 3'd3, 1'b1);
    send_word(32'h00000000, CountFull, 1'b1);
    send_word(32'hffffffff, CountFull, 1'b1);
    send_word(32'h89abcdef, 3'd5, 1'b1);           // oversized counts act as full
    send_word(32'h01234567, 3'd6, 1'b1);
    send_word(32'hffffffff, 3'd7, 1'b1);
    send_word(32'h64636261, CountFull, 1'b0);
    send_word(32'h68676665, CountFull, 1'b0);
    send_word(32'hff6b6a69, 3'd3, 1'b1);
    send_word(32'hdeadbeef, 3'd2, 1'b0);           // short word mid-key
    send_word(32'hcafef00d, CountFull, 1'b0);
    send_word(32'h12345678, 3'd1, 1'b1);
    send_word(32'h87654321, 3'd0, 1'b0);           // zero count mid-key
    send_word(32'h0badf00d, CountFull, 1'b0);
    send_word(32'h13579bdf, 3'd0, 1'b1);
    send_word(32'hffffffff, 3'd7, 1'b0);
    send_word(32'hffffffff, CountFull, 1'b1);
    send_word(32'h80000001, 3'd0, 1'b0);
    send_word(32'h7ffffffe, 3'd0, 1'b1);
  endtask

  initial begin : out_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 0;
        hold_left = LongHold;
      end
      if (hold_left == 0) hold_left = pick_gap();
      out_ch.ready = (hold_left == 0);
      if (hold_left > 0) hold_left--;
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) hash_calc.check_hash(out_ch.hash_value);
    end
  end

  initial begin : in_side
    logic [31:0] seeds[6];
    int p;
    clk              = 1'b0;
    rst_n            = 1'b0;
    quiet            = 0;
    long_hold        = 0;
    cycle_count      = 0;
    in_ch.valid      = 1'b0;
    in_ch.data_word  = '0;
    in_ch.byte_count = '0;
    in_ch.last       = 1'b0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.seed      = '0;
    seeds[0] = 32'h00000000;
    seeds[1] = 32'hffffffff;
    seeds[2] = $urandom;
    seeds[3] = 32'h80000000;
    seeds[4] = $urandom;
    seeds[5] = SeedReset;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    for (p = 0; p < 6; p++) begin
      wait_drained();
      write_seed(seeds[p]);
      // one phase with no gaps, opened by a long output stall to back up the queue
      quiet = (p == 2);
      if (p == 2) long_hold = 1;
      run_keys(270);
    end
    quiet = 0;
    wait_drained();
    repeat (20) @(negedge clk);

    if (hash_calc.errors == 0 && hash_calc.pending() == 0) begin
      $display("murmur3_32_hash_unit_test: done, clean");
    end else begin
      $display("murmur3_32_hash_unit_test: done, errors");
    end
    $finish;
  end

endmodule
